@@ hdl/mec_pkg.sv @@
// Shared types, constants and register codes for the Mandelbrot escape-count block.
package mec_pkg;

   localparam int FRAC_BITS   = 28;
   localparam int COORD_WIDTH = 32;
   localparam int INDEX_WIDTH = 12;
   localparam int ITER_WIDTH  = 16;
   localparam int SQ_WIDTH    = 36;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 32;

   localparam int MAX_WIDTH_DEFAULT  = 4096;
   localparam int MAX_HEIGHT_DEFAULT = 4096;
   localparam int NUM_CELLS_DEFAULT  = 4;

   // 4.0 in Q.28, the escape threshold for |z|^2.
   localparam logic [SQ_WIDTH-1:0] FOUR_Q28 = SQ_WIDTH'(64'd1 << (FRAC_BITS + 2));

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ORIGIN_REAL = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ORIGIN_IMAG = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_STEP_X      = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_STEP_Y      = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_ITER    = 3'd4;

   localparam logic signed [COORD_WIDTH-1:0] ORIGIN_REAL_RESET = -32'sd671088640;
   localparam logic signed [COORD_WIDTH-1:0] ORIGIN_IMAG_RESET = -32'sd536870912;
   localparam logic signed [COORD_WIDTH-1:0] STEP_X_RESET      = 32'sd13421773;
   localparam logic signed [COORD_WIDTH-1:0] STEP_Y_RESET      = 32'sd26843546;
   localparam logic [ITER_WIDTH-1:0]         MAX_ITER_RESET    = 16'd256;

   // One pixel in flight: the squares and cross term of the current z, plus c.
   typedef struct packed {
      logic                          active;
      logic [ITER_WIDTH-1:0]         iter;
      logic [SQ_WIDTH-1:0]           sq_r;
      logic [SQ_WIDTH-1:0]           sq_i;
      logic signed [COORD_WIDTH-1:0] cross_term;
      logic signed [COORD_WIDTH-1:0] cr;
      logic signed [COORD_WIDTH-1:0] ci;
   } slot_type;

   typedef struct packed {
      logic                  done;
      logic [ITER_WIDTH-1:0] count;
   } finish_type;

   typedef struct packed {
      logic                          valid;
      logic                          outside;
      logic signed [COORD_WIDTH-1:0] cr;
      logic signed [COORD_WIDTH-1:0] ci;
   } point_type;

endpackage

@@ hdl/mec_coord.sv @@
// Front end that maps a pixel index to the point c in Q4.28, with saturation.
module mec_coord #(
   parameter int MAX_WIDTH  = mec_pkg::MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = mec_pkg::MAX_HEIGHT_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   in_valid,
   input  logic [mec_pkg::INDEX_WIDTH-1:0]        column,
   input  logic [mec_pkg::INDEX_WIDTH-1:0]        line,
   input  logic signed [mec_pkg::COORD_WIDTH-1:0] origin_real,
   input  logic signed [mec_pkg::COORD_WIDTH-1:0] origin_imag,
   input  logic signed [mec_pkg::COORD_WIDTH-1:0] step_x,
   input  logic signed [mec_pkg::COORD_WIDTH-1:0] step_y,
   output logic                                   busy,
   output mec_pkg::point_type                     point
);
   import mec_pkg::*;

   localparam int PROD_WIDTH = INDEX_WIDTH + 1 + COORD_WIDTH;
   localparam int SUM_WIDTH  = PROD_WIDTH + 1;
   localparam logic [16:0] COL_LIMIT  = 17'(MAX_WIDTH);
   localparam logic [16:0] LINE_LIMIT = 17'(MAX_HEIGHT);
   localparam logic signed [SUM_WIDTH-1:0] Q_MAX = 46'sd2147483647;
   localparam logic signed [SUM_WIDTH-1:0] Q_MIN = -46'sd2147483648;

   logic                          a_valid_ff;
   logic [INDEX_WIDTH-1:0]        col_ff;
   logic [INDEX_WIDTH-1:0]        line_ff;
   logic                          b_valid_ff;
   logic                          b_outside_ff;
   logic signed [PROD_WIDTH-1:0]  prod_r_ff;
   logic signed [PROD_WIDTH-1:0]  prod_i_ff;
   logic signed [PROD_WIDTH-1:0]  prod_r_in;
   logic signed [PROD_WIDTH-1:0]  prod_i_in;
   logic signed [SUM_WIDTH-1:0]   sum_r;
   logic signed [SUM_WIDTH-1:0]   sum_i;
   point_type                     point_ff;
   point_type                     point_in;

   function automatic logic signed [COORD_WIDTH-1:0] saturate(
      input logic signed [SUM_WIDTH-1:0] v
   );
      logic signed [COORD_WIDTH-1:0] r;
      if (v > Q_MAX) begin
         r = Q_MAX[COORD_WIDTH-1:0];
      end else if (v < Q_MIN) begin
         r = Q_MIN[COORD_WIDTH-1:0];
      end else begin
         r = v[COORD_WIDTH-1:0];
      end
      return r;
   endfunction

   assign prod_r_in = $signed({1'b0, col_ff}) * step_x;
   assign prod_i_in = $signed({1'b0, line_ff}) * step_y;

   assign sum_r = $signed({prod_r_ff[PROD_WIDTH-1], prod_r_ff})
                + $signed({{(SUM_WIDTH-COORD_WIDTH){origin_real[COORD_WIDTH-1]}}, origin_real});
   assign sum_i = $signed({prod_i_ff[PROD_WIDTH-1], prod_i_ff})
                + $signed({{(SUM_WIDTH-COORD_WIDTH){origin_imag[COORD_WIDTH-1]}}, origin_imag});

   always_comb begin
      point_in.valid   = b_valid_ff;
      point_in.outside = b_outside_ff;
      point_in.cr      = saturate(sum_r);
      point_in.ci      = saturate(sum_i);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff     <= 1'b0;
         b_valid_ff     <= 1'b0;
         point_ff.valid <= 1'b0;
      end else begin
         a_valid_ff     <= in_valid;
         b_valid_ff     <= a_valid_ff;
         point_ff.valid <= point_in.valid;
      end
      if (in_valid) begin
         col_ff  <= column;
         line_ff <= line;
      end
      prod_r_ff        <= prod_r_in;
      prod_i_ff        <= prod_i_in;
      b_outside_ff     <= ({5'd0, col_ff} >= COL_LIMIT) || ({5'd0, line_ff} >= LINE_LIMIT);
      point_ff.outside <= point_in.outside;
      point_ff.cr      <= point_in.cr;
      point_ff.ci      <= point_in.ci;
   end

   assign busy  = a_valid_ff | b_valid_ff | point_ff.valid;
   assign point = point_ff;

endmodule

@@ hdl/mec_cell.sv @@
// One cell of the iteration ring: tests escape and performs one z = z*z + c step.
module mec_cell (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [mec_pkg::ITER_WIDTH-1:0]        max_iter,
   input  mec_pkg::slot_type                     prev_slot,
   output mec_pkg::slot_type                     next_slot,
   output mec_pkg::finish_type                   finish
);
   import mec_pkg::*;

   logic [SQ_WIDTH:0]               mag_sum;
   logic                            escaped;
   logic                            run;
   logic signed [COORD_WIDTH:0]     nr;
   logic signed [COORD_WIDTH:0]     ni;
   logic signed [COORD_WIDTH:0]     nr_neg;
   logic signed [COORD_WIDTH:0]     ni_neg;
   logic [COORD_WIDTH-1:0]          mr;
   logic [COORD_WIDTH-1:0]          mi;
   logic [2*COORD_WIDTH-1:0]        sqr_full;
   logic [2*COORD_WIDTH-1:0]        sqi_full;
   logic signed [59:0]              cross_full;
   slot_type                        slot_ff;
   slot_type                        slot_in;

   assign mag_sum = {1'b0, prev_slot.sq_r} + {1'b0, prev_slot.sq_i};
   assign escaped = mag_sum >= {1'b0, FOUR_Q28};
   assign run     = prev_slot.active && !escaped && (prev_slot.iter < max_iter);

   assign finish.done  = prev_slot.active && !run;
   assign finish.count = (prev_slot.iter == max_iter) ? '0 : prev_slot.iter;

   // While the pixel keeps running both squares are below 4.0, so the low 30 bits are exact.
   assign nr = $signed({3'b000, prev_slot.sq_r[29:0]}) - $signed({3'b000, prev_slot.sq_i[29:0]})
             + $signed({prev_slot.cr[COORD_WIDTH-1], prev_slot.cr});
   assign ni = $signed({prev_slot.cross_term[COORD_WIDTH-1], prev_slot.cross_term})
             + $signed({prev_slot.ci[COORD_WIDTH-1], prev_slot.ci});

   assign nr_neg = -nr;
   assign ni_neg = -ni;
   assign mr = nr[COORD_WIDTH] ? nr_neg[COORD_WIDTH-1:0] : nr[COORD_WIDTH-1:0];
   assign mi = ni[COORD_WIDTH] ? ni_neg[COORD_WIDTH-1:0] : ni[COORD_WIDTH-1:0];

   assign sqr_full = {32'd0, mr} * {32'd0, mr};
   assign sqi_full = {32'd0, mi} * {32'd0, mi};

   // The cross term is only used if the new z does not escape, and then both parts
   // lie within 30 signed bits; otherwise this product is ignored.
   assign cross_full = $signed({{30{nr[29]}}, nr[29:0]}) * $signed({{30{ni[29]}}, ni[29:0]});

   always_comb begin
      slot_in.active     = run;
      slot_in.iter       = prev_slot.iter + 16'd1;
      slot_in.sq_r       = sqr_full[2*COORD_WIDTH-1:FRAC_BITS];
      slot_in.sq_i       = sqi_full[2*COORD_WIDTH-1:FRAC_BITS];
      slot_in.cross_term = cross_full[58:FRAC_BITS-1];
      slot_in.cr         = prev_slot.cr;
      slot_in.ci         = prev_slot.ci;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff.active <= 1'b0;
      end else begin
         slot_ff.active <= slot_in.active;
      end
      slot_ff.iter       <= slot_in.iter;
      slot_ff.sq_r       <= slot_in.sq_r;
      slot_ff.sq_i       <= slot_in.sq_i;
      slot_ff.cross_term <= slot_in.cross_term;
      slot_ff.cr         <= slot_in.cr;
      slot_ff.ci         <= slot_in.ci;
   end

   assign next_slot = slot_ff;

endmodule

@@ hdl/mandelbrot_escape_count_top.sv @@
// Top level of the Mandelbrot escape-count block: registers, iteration ring, result path.
//
// A pixel (req_column, req_line) is taken in one beat on the request channel when
// req_valid is high and req_stall is low. The block maps it to c, then runs
// z = z*z + c in a ring of identical cells, one iteration per cell per cycle, the
// pixel moving to the next cell each cycle. One result beat per pixel leaves on
// rsp_valid / rsp_escape_count, in request order.
// A request passes the index, product and point registers of mec_coord before it
// enters the ring. A pixel runs max_iter iterations if it stays bounded and none if
// it lies outside the image. One pixel is mapped and iterated at a time: the next
// request beat is taken only once the previous pixel has left mec_coord and the ring.
// A finished result waits in the output register while rsp_stall is high; a second
// finished result waits in a holding register, and requests are held off with
// req_stall until it has moved on. Nothing is lost or repeated under stall.
// The csr_ port writes one register per cycle when csr_write_enable is high; the user
// must write it only while the block is idle; the block does not enforce it. Reset is
// synchronous, restores register defaults and empties the block without a clearing pass.
module mandelbrot_escape_count_top #(
   parameter int MAX_WIDTH  = mec_pkg::MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = mec_pkg::MAX_HEIGHT_DEFAULT,
   parameter int NUM_CELLS  = mec_pkg::NUM_CELLS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [mec_pkg::INDEX_WIDTH-1:0]       req_column,
   input  logic [mec_pkg::INDEX_WIDTH-1:0]       req_line,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [mec_pkg::ITER_WIDTH-1:0]        rsp_escape_count,
   input  logic                                  csr_write_enable,
   input  logic [mec_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [mec_pkg::CSR_DATA_WIDTH-1:0]    csr_write_data
);
   import mec_pkg::*;

   logic signed [COORD_WIDTH-1:0] origin_real_ff;
   logic signed [COORD_WIDTH-1:0] origin_imag_ff;
   logic signed [COORD_WIDTH-1:0] step_x_ff;
   logic signed [COORD_WIDTH-1:0] step_y_ff;
   logic [ITER_WIDTH-1:0]         max_iter_ff;

   logic                          req_accept;
   logic                          coord_busy;
   point_type                     point;
   slot_type                      inject_slot;
   slot_type                      cell_input [NUM_CELLS];
   slot_type                      cell_output [NUM_CELLS];
   finish_type                    cell_finish [NUM_CELLS];
   logic                          ring_active;
   logic                          done_any;
   logic [ITER_WIDTH-1:0]         done_count;

   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   logic [ITER_WIDTH-1:0]         rsp_count_ff;
   logic [ITER_WIDTH-1:0]         rsp_count_in;
   logic                          pend_valid_ff;
   logic                          pend_valid_in;
   logic [ITER_WIDTH-1:0]         pend_count_ff;
   logic [ITER_WIDTH-1:0]         pend_count_in;
   logic                          rsp_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_real_ff <= ORIGIN_REAL_RESET;
         origin_imag_ff <= ORIGIN_IMAG_RESET;
         step_x_ff      <= STEP_X_RESET;
         step_y_ff      <= STEP_Y_RESET;
         max_iter_ff    <= MAX_ITER_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_ORIGIN_REAL: origin_real_ff <= $signed(csr_write_data);
            CSR_ORIGIN_IMAG: origin_imag_ff <= $signed(csr_write_data);
            CSR_STEP_X:      step_x_ff      <= $signed(csr_write_data);
            CSR_STEP_Y:      step_y_ff      <= $signed(csr_write_data);
            CSR_MAX_ITER:    max_iter_ff    <= csr_write_data[ITER_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   assign req_stall  = coord_busy | ring_active | pend_valid_ff;
   assign req_accept = req_valid & ~req_stall;

   mec_coord #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_coord (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_accept),
      .column      (req_column),
      .line        (req_line),
      .origin_real (origin_real_ff),
      .origin_imag (origin_imag_ff),
      .step_x      (step_x_ff),
      .step_y      (step_y_ff),
      .busy        (coord_busy),
      .point       (point)
   );

   // A pixel outside the image enters with |z|^2 already at 4.0 and zero iterations,
   // so the first cell retires it with a count of zero.
   always_comb begin
      inject_slot.active     = 1'b1;
      inject_slot.iter       = '0;
      inject_slot.sq_r       = point.outside ? FOUR_Q28 : '0;
      inject_slot.sq_i       = '0;
      inject_slot.cross_term = '0;
      inject_slot.cr         = point.cr;
      inject_slot.ci         = point.ci;
   end

   // The ring is empty whenever a new point arrives, so injection never collides.
   generate
      for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
         if (i == 0) begin : g_head
            assign cell_input[i] = point.valid ? inject_slot : cell_output[NUM_CELLS-1];
         end else begin : g_body
            assign cell_input[i] = cell_output[i-1];
         end
         mec_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .max_iter  (max_iter_ff),
            .prev_slot (cell_input[i]),
            .next_slot (cell_output[i]),
            .finish    (cell_finish[i])
         );
      end
   endgenerate

   always_comb begin
      ring_active = 1'b0;
      done_any    = 1'b0;
      done_count  = '0;
      for (int i = 0; i < NUM_CELLS; i++) begin
         ring_active = ring_active | cell_output[i].active;
         done_any    = done_any | cell_finish[i].done;
         done_count  = done_count | (cell_finish[i].done ? cell_finish[i].count : '0);
      end
   end

   assign rsp_free = ~rsp_valid_ff | ~rsp_stall;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      rsp_count_in  = rsp_count_ff;
      pend_valid_in = pend_valid_ff;
      pend_count_in = pend_count_ff;
      if (pend_valid_ff) begin
         if (rsp_free) begin
            rsp_valid_in  = 1'b1;
            rsp_count_in  = pend_count_ff;
            pend_valid_in = 1'b0;
         end
      end else if (done_any) begin
         if (rsp_free) begin
            rsp_valid_in = 1'b1;
            rsp_count_in = done_count;
         end else begin
            pend_valid_in = 1'b1;
            pend_count_in = done_count;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
      rsp_count_ff  <= rsp_count_in;
      pend_count_ff <= pend_count_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_escape_count = rsp_count_ff;

endmodule
